// File: hdl/sdlcg_pkg.sv
package sdlcg_pkg;

    localparam int VAL_W          = 31;
    localparam int MUL_W          = 16;
    localparam int PROD_W         = VAL_W + MUL_W;
    localparam int DEF_TABLE_SIZE = 32;
    localparam int WARM_EXTRA     = 8;

    localparam logic [31:0] MOD1      = 32'd2147483563;
    localparam logic [31:0] MOD2      = 32'd2147483399;
    localparam logic [31:0] MOD1_LESS = 32'd2147483562;

    localparam logic [MUL_W-1:0] MUL1 = 16'd40014;
    localparam logic [MUL_W-1:0] MUL2 = 16'd40692;

    // 2^31 mod m for each modulus
    localparam logic [7:0] COMP1 = 8'd85;
    localparam logic [7:0] COMP2 = 8'd249;

    localparam logic [VAL_W-1:0] FIRST_INIT  = 31'd1;
    localparam logic [VAL_W-1:0] SECOND_INIT = 31'd123456789;

    localparam logic CMD_RESEED = 1'b1;

    localparam logic [1:0] STEP_WAIT = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WARM,
        S_ALIGN,
        S_READ,
        S_COMMIT
    } state_t;

    typedef struct packed {
        logic load_seed;
        logic warm_step;
        logic read_slot;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic warm_last;
        logic out_free;
    } dp_status_t;

    // fold a product below 2^47 into [0, m) using 2^31 = comp (mod m)
    function automatic logic [VAL_W-1:0] fold_mod(
        input logic [PROD_W-1:0] p,
        input logic [7:0]        comp,
        input logic [31:0]       modulus
    );
        logic [31:0] s;
        logic [31:0] r;
        s = ({16'd0, p[PROD_W-1:VAL_W]} * {24'd0, comp}) + {1'b0, p[VAL_W-1:0]};
        r = (s >= modulus) ? (s - modulus) : s;
        return r[VAL_W-1:0];
    endfunction

endpackage

// File: hdl/sdlcg_ctrl.sv
module sdlcg_ctrl import sdlcg_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_cmd,
    output logic       s_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t     state_reg;
    state_t     state_next;
    logic [1:0] phase_reg;
    logic [1:0] phase_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            phase_reg <= '0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd        = '0;
        s_ready    = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (s_cmd == CMD_RESEED) begin
                        cmd.load_seed = 1'b1;
                        phase_next    = '0;
                        state_next    = S_WARM;
                    end else begin
                        state_next = S_READ;
                    end
                end
            end
            S_WARM: begin
                if (phase_reg == STEP_WAIT) begin
                    cmd.warm_step = 1'b1;
                    phase_next    = '0;
                    if (status.warm_last) begin
                        state_next = S_ALIGN;
                    end
                end else begin
                    phase_next = phase_reg + 2'd1;
                end
            end
            S_ALIGN: begin
                state_next = S_READ;
            end
            S_READ: begin
                cmd.read_slot = 1'b1;
                state_next    = S_COMMIT;
            end
            S_COMMIT: begin
                if (status.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> status.out_free)
        else $error("commit while output word still held");

    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cmd))
        else $error("more than one datapath command");

    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WARM) |-> (phase_reg <= STEP_WAIT))
        else $error("warm-up phase out of range");

endmodule

// File: hdl/sdlcg_datapath.sv
module sdlcg_datapath import sdlcg_pkg::*; #(
    parameter int TABLE_SIZE = DEF_TABLE_SIZE
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [VAL_W-1:0] s_seed,
    input  dp_cmd_t          cmd,
    output dp_status_t       status,
    input  logic             m_ready,
    output logic             m_valid,
    output logic [VAL_W-1:0] m_value
);

    localparam int IDX_W  = $clog2(TABLE_SIZE);
    localparam int WARM_W = $clog2(TABLE_SIZE + WARM_EXTRA);

    localparam logic [63:0] NDIV       = 64'd1 + {32'd0, MOD1_LESS} / 64'(TABLE_SIZE);
    localparam int          SLOT_SHIFT = VAL_W + $clog2(NDIV);
    localparam logic [63:0] RECIP      = ((64'd1 << SLOT_SHIFT) + NDIV - 64'd1) / NDIV;

    logic [VAL_W-1:0]  first_gen_reg;
    logic [VAL_W-1:0]  first_gen_next;
    logic [VAL_W-1:0]  second_gen_reg;
    logic [VAL_W-1:0]  second_gen_next;
    logic [VAL_W-1:0]  shuffle_out_reg;
    logic [VAL_W-1:0]  shuffle_out_next;
    logic [WARM_W-1:0] warm_cnt_reg;
    logic [WARM_W-1:0] warm_cnt_next;
    logic [TABLE_SIZE-1:0] valid_reg;
    logic [TABLE_SIZE-1:0] valid_next;
    logic              m_valid_reg;
    logic              m_valid_next;
    logic [VAL_W-1:0]  m_value_reg;

    logic [PROD_W-1:0] prod1_reg;
    logic [PROD_W-1:0] prod2_reg;
    logic [VAL_W-1:0]  y1_reg;
    logic [VAL_W-1:0]  y2_reg;
    logic [63:0]       slot_prod_reg;

    logic [VAL_W-1:0]  slot_mem [TABLE_SIZE];
    logic [VAL_W-1:0]  rd_data_reg;
    logic              rd_ok_reg;

    logic [IDX_W-1:0]  slot;
    logic [VAL_W-1:0]  seed_eff;
    logic              warm_wr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [VAL_W-1:0]  entry;
    logic [31:0]       diff;
    logic [31:0]       wrapped;
    logic [VAL_W-1:0]  draw_value;

    // free-running generator steps: each state goes through a product register, then a fold register
    always_ff @(posedge aclk) begin
        prod1_reg     <= {16'd0, first_gen_reg} * {31'd0, MUL1};
        prod2_reg     <= {16'd0, second_gen_reg} * {31'd0, MUL2};
        y1_reg        <= fold_mod(prod1_reg, COMP1, MOD1);
        y2_reg        <= fold_mod(prod2_reg, COMP2, MOD2);
        slot_prod_reg <= {33'd0, shuffle_out_reg} * RECIP;
    end

    assign slot = slot_prod_reg[SLOT_SHIFT +: IDX_W];

    assign seed_eff = (s_seed == '0) ? FIRST_INIT : s_seed;
    assign warm_wr  = cmd.warm_step && (warm_cnt_reg < WARM_W'(TABLE_SIZE));
    assign wr_en    = warm_wr || cmd.commit;
    assign wr_addr  = cmd.commit ? slot : warm_cnt_reg[IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_mem[wr_addr] <= y1_reg;
        end
        if (cmd.read_slot) begin
            rd_data_reg <= slot_mem[slot];
            rd_ok_reg   <= valid_reg[slot];
        end
        if (cmd.commit) begin
            m_value_reg <= draw_value;
        end
    end

    assign entry      = rd_ok_reg ? rd_data_reg : '0;
    assign diff       = {1'b0, entry} - {1'b0, y2_reg};
    assign wrapped    = (diff[31] || diff == '0) ? (diff + MOD1_LESS) : diff;
    assign draw_value = wrapped[VAL_W-1:0];

    always_comb begin
        first_gen_next   = first_gen_reg;
        second_gen_next  = second_gen_reg;
        shuffle_out_next = shuffle_out_reg;
        warm_cnt_next    = warm_cnt_reg;
        valid_next       = valid_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        if (cmd.load_seed) begin
            first_gen_next  = seed_eff;
            second_gen_next = seed_eff;
            warm_cnt_next   = WARM_W'(TABLE_SIZE + WARM_EXTRA - 1);
        end
        if (cmd.warm_step) begin
            first_gen_next = y1_reg;
            if (warm_cnt_reg == '0) begin
                shuffle_out_next = y1_reg;
            end else begin
                warm_cnt_next = warm_cnt_reg - 1'b1;
            end
        end
        if (wr_en) begin
            valid_next[wr_addr] = 1'b1;
        end
        if (cmd.commit) begin
            first_gen_next   = y1_reg;
            second_gen_next  = y2_reg;
            shuffle_out_next = draw_value;
            m_valid_next     = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_gen_reg   <= FIRST_INIT;
            second_gen_reg  <= SECOND_INIT;
            shuffle_out_reg <= '0;
            warm_cnt_reg    <= '0;
            valid_reg       <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            first_gen_reg   <= first_gen_next;
            second_gen_reg  <= second_gen_next;
            shuffle_out_reg <= shuffle_out_next;
            warm_cnt_reg    <= warm_cnt_next;
            valid_reg       <= valid_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    assign status.warm_last = (warm_cnt_reg == '0);
    assign status.out_free  = !m_valid_reg || m_ready;
    assign m_valid          = m_valid_reg;
    assign m_value          = m_value_reg;

    a_value_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_value_reg != '0))
        else $error("output word out of range");

    a_commit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_valid_reg)
        else $error("committed word not presented");

    a_warm_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        warm_cnt_reg <= WARM_W'(TABLE_SIZE + WARM_EXTRA - 1))
        else $error("warm-up count out of range");

endmodule

// File: hdl/shuffled_dual_lcg_random.sv
// Combined two-generator random source with a TABLE_SIZE-entry shuffle table.
// A draw word (s_cmd = 0) reads the shuffle table in S_READ at the slot
// picked by the last output, then in S_COMMIT forms the result and presents
// it once the output register is free. The block is back in idle in the
// cycle m_valid rises. The two modular multiply pipelines run through a
// product register and a fold register behind the generator state and are
// ready by the time the commit needs them. A reseed word (s_cmd = 1) runs
// TABLE_SIZE+8 warm-up steps of the first generator, each waiting for its
// multiply/fold pipeline, then passes S_ALIGN and draws once. The block takes
// a new word while a finished result still waits on m_ready; a result waits
// only for the output register to free. Draws before any reseed run from the
// reset state with an all-zero table.
module shuffled_dual_lcg_random import sdlcg_pkg::*; #(
    parameter int TABLE_SIZE = DEF_TABLE_SIZE
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_cmd,
    input  logic [VAL_W-1:0] s_seed,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [VAL_W-1:0] m_value
);

    dp_cmd_t    cmd;
    dp_status_t status;

    sdlcg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_cmd   (s_cmd),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    sdlcg_datapath #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_seed  (s_seed),
        .cmd     (cmd),
        .status  (status),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_value (m_value)
    );

endmodule
